### design/sbtc_pkg.sv
package sbtc_pkg;

   // Depth of the result queue between the front and the back part.
   localparam int QUEUE_DEPTH = 4;

   // Mode register codes.
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // One queue entry holds the one or two result items caused by one input item.
   typedef struct packed {
      logic       pair;
      logic [7:0] byte0;
      logic       last0;
      logic [7:0] byte1;
      logic       last1;
   } sbtc_entry_type;

   typedef struct packed {
      logic           valid;
      sbtc_entry_type entry;
   } sbtc_push_type;

endpackage

### design/sbtc_front.sv
module sbtc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tlast,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    queue_full,
   output sbtc_pkg::sbtc_push_type push
);
   import sbtc_pkg::*;

   localparam logic [1:0] PHASE_ZERO  = 2'd0;
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;
   localparam logic [1:0] PHASE_THREE = 2'd3;
   localparam logic [7:0] SYM_BASE    = 8'd65;

   logic       mode_ff, mode_in;
   logic [1:0] phase_ff, phase_in;
   logic [5:0] carry_ff, carry_in;
   logic       accept;
   logic [5:0] sym_val;
   logic [5:0] next_carry;

   function automatic logic [7:0] to_symbol(input logic [5:0] v);
      return {2'b00, v} + SYM_BASE;
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   // (symbol - 65) mod 64 only needs the low six bits, and 65 mod 64 is one.
   assign sym_val    = req_tdata[5:0] - 6'd1;

   always_comb begin
      mode_in    = mode_ff;
      phase_in   = phase_ff;
      carry_in   = carry_ff;
      next_carry = 6'd0;
      push       = '0;
      if (csr_wr_en) begin
         mode_in  = csr_wr_data;
         phase_in = PHASE_ZERO;
         carry_in = 6'd0;
      end else if (accept) begin
         if (mode_ff == MODE_DECODE) begin
            unique case (phase_ff)
               PHASE_ZERO: begin
                  carry_in = sym_val;
                  phase_in = PHASE_ONE;
               end
               PHASE_ONE: begin
                  push.valid       = 1'b1;
                  push.entry.byte0 = {carry_ff, sym_val[5:4]};
                  push.entry.last0 = req_tlast;
                  carry_in         = {2'b00, sym_val[3:0]};
                  phase_in         = PHASE_TWO;
               end
               PHASE_TWO: begin
                  push.valid       = 1'b1;
                  push.entry.byte0 = {carry_ff[3:0], sym_val[5:2]};
                  push.entry.last0 = req_tlast;
                  carry_in         = {4'b0000, sym_val[1:0]};
                  phase_in         = PHASE_THREE;
               end
               PHASE_THREE: begin
                  push.valid       = 1'b1;
                  push.entry.byte0 = {carry_ff[1:0], sym_val};
                  push.entry.last0 = req_tlast;
                  carry_in         = 6'd0;
                  phase_in         = PHASE_ZERO;
               end
               default: begin
                  phase_in = PHASE_ZERO;
               end
            endcase
         end else begin
            push.valid = 1'b1;
            case (phase_ff)
               PHASE_ONE: begin
                  push.entry.byte0 = to_symbol(carry_ff | {2'b00, req_tdata[7:4]});
                  next_carry       = {req_tdata[3:0], 2'b00};
                  carry_in         = next_carry;
                  phase_in         = PHASE_TWO;
               end
               PHASE_TWO: begin
                  push.entry.byte0 = to_symbol(carry_ff | {4'b0000, req_tdata[7:6]});
                  push.entry.pair  = 1'b1;
                  push.entry.byte1 = to_symbol(req_tdata[5:0]);
                  push.entry.last1 = req_tlast;
                  carry_in         = 6'd0;
                  phase_in         = PHASE_ZERO;
               end
               default: begin
                  push.entry.byte0 = to_symbol(req_tdata[7:2]);
                  next_carry       = {req_tdata[1:0], 4'b0000};
                  carry_in         = next_carry;
                  phase_in         = PHASE_ONE;
               end
            endcase
            // An incomplete group is flushed as one more symbol, low bits zero.
            if (req_tlast && phase_ff != PHASE_TWO) begin
               push.entry.pair  = 1'b1;
               push.entry.byte1 = to_symbol(next_carry);
               push.entry.last1 = 1'b1;
            end
         end
         if (req_tlast) begin
            phase_in = PHASE_ZERO;
            carry_in = 6'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ENCODE;
         phase_ff <= PHASE_ZERO;
         carry_ff <= 6'd0;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

### design/sbtc_queue.sv
module sbtc_queue #(
   parameter int DEPTH = sbtc_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sbtc_pkg::sbtc_push_type  push,
   input  logic                     pop,
   output logic                     full,
   output logic                     empty,
   output sbtc_pkg::sbtc_entry_type head
);
   import sbtc_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   sbtc_entry_type     entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == FULL_COUNT);
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push.valid && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.entry;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT) else $error("queue count beyond depth");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push.valid) else $error("push into a full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from an empty queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_COUNT) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

### design/sbtc_back.sv
module sbtc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     empty,
   input  sbtc_pkg::sbtc_entry_type head,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               rsp_tdata,
   output logic                     rsp_tlast
);
   import sbtc_pkg::*;

   logic       valid_ff, valid_in;
   logic       sub_ff, sub_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       load;

   // The output register is refilled whenever the queue holds an entry and the register is empty or being taken.
   assign load = !empty && (!valid_ff || rsp_tready);
   assign pop  = load && (sub_ff || !head.pair);

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      sub_in   = sub_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = !pop;
         data_in  = sub_ff ? head.byte1 : head.byte0;
         last_in  = sub_ff ? head.last1 : head.last0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### design/six_bit_text_codec.sv
// Streaming base64-style codec whose alphabet is the 64 byte codes from 65 up.
// Input items arrive on the req_ channel: a data byte in encode mode or a
// symbol byte in decode mode, with req_tlast marking the end of a message.
// Results leave on the rsp_ channel, one item per accepted handshake, with
// rsp_tlast on the final result of a message. csr_wr_en writes the mode bit
// (0 encode, 1 decode) and restarts the group; write it only while idle.
// An accepted item's first result passes through the result queue and then
// the output register before it shows on rsp_. The front part takes one item
// per cycle while its result queue has room; the back part drives one result
// per cycle through the output register while the receiver takes them, so the
// sustained rate is set by the result channel. When encoding, three bytes give
// four symbols, and an item that closes a group or a message gives two; when
// decoding, one item per cycle is kept up.
// When the receiver stalls, the output register holds its item, the queue
// fills, and req_tready falls once the queue is full. Reset clears the mode
// to encode, the group phase, the leftover bits, the queue and the output.
module six_bit_text_codec #(
   parameter int QUEUE_DEPTH = sbtc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import sbtc_pkg::*;

   sbtc_push_type  push;
   sbtc_entry_type head;
   logic           queue_full;
   logic           queue_empty;
   logic           pop;

   // The front part keeps the mode, the group phase and the leftover bits, and
   // turns each accepted item into a queue entry of zero, one or two results.
   sbtc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push)
   );

   sbtc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (head)
   );

   // The back part sends the results of each entry in order, one per cycle while rsp_tready is high.
   sbtc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
